// ===== sv/linear_probe_hash_table_unit_macros.svh =====
// Assertion macros for the hash table unit.
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`ifndef SYNTH
`define LPH_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define LPH_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define LPH_ASSERT_IMP(label, clk, rst_n, a, c)
`define LPH_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== sv/lpht_pkg.sv =====
// Package with shared types and constants of the hash table unit.
package lpht_pkg;
	localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam int CAP_PAD = 8;
	localparam logic [1:0] ST_FOUND = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HASH, S_MOD, S_READ, S_CHECK, S_OUT
	} state_t;
endpackage

// ===== sv/lpht_hash.sv =====
// Byte-serial FNV-1a hash of a normalized key.
module lpht_hash #(
	parameter int KEY_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] key,
	output logic        done,
	output logic [31:0] hash
);
	import lpht_pkg::*;
	localparam int BW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES + 1) : 1;
	logic [31:0] h_q;
	logic [63:0] k_q;
	logic [BW-1:0] n_q;
	logic busy_q;
	logic [31:0] x;
	assign x = h_q ^ {24'd0, k_q[7:0]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			n_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			n_q <= '0;
		end else if (busy_q) begin
			if (k_q[7:0] == 8'd0 || n_q == BW'(KEY_BYTES)) busy_q <= 1'b0;
			else n_q <= n_q + 1'b1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= FNV_OFFSET;
			k_q <= key;
		end else if (busy_q && k_q[7:0] != 8'd0 && n_q != BW'(KEY_BYTES)) begin
			h_q <= x * FNV_PRIME;
			k_q <= k_q >> 8;
		end
	end
	assign done = busy_q && (k_q[7:0] == 8'd0 || n_q == BW'(KEY_BYTES));
	assign hash = h_q;
endmodule

// ===== sv/lpht_mod.sv =====
// Restoring remainder of a 32-bit hash by the capacity, one bit a cycle.
module lpht_mod #(
	parameter int CW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   dividend,
	input  logic [CW-1:0] divisor,
	output logic          done,
	output logic [CW-1:0] rem
);
	import lpht_pkg::*;
	logic [31:0] d_q;
	logic [CW:0] r_q;
	logic [5:0] n_q;
	logic busy_q;
	logic [CW:0] sh;
	assign sh = {r_q[CW-1:0], d_q[31]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			n_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			n_q <= 6'd0;
		end else if (busy_q) begin
			if (n_q == 6'd32) busy_q <= 1'b0;
			else n_q <= n_q + 6'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= dividend;
			r_q <= '0;
		end else if (busy_q && n_q != 6'd32) begin
			d_q <= d_q << 1;
			r_q <= (sh >= {1'b0, divisor}) ? sh - {1'b0, divisor} : sh;
		end
	end
	assign done = busy_q && n_q == 6'd32;
	assign rem = r_q[CW-1:0];
endmodule

// ===== sv/linear_probe_hash_table_unit.sv =====
// Top level of the hash table unit with slot memories and probe control.
// A request passes the hash step, the remainder step, then a read and a check state
// per probed slot, and an output state; one request is processed at a time.
// The probe walk through the synchronous slot memory sets the per-slot cost.
// Reset and every capacity write taken in the idle state start a clearing pass
// over the used marks, during which no request is accepted.
module linear_probe_hash_table_unit #(
	parameter int SLOTS = 1024,
	parameter int KEY_BYTES = 8,
	parameter int DATA_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [9:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // key_bytes, data_in
	input  logic        s_tuser,  // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // slot_index, data_out, zero pad
	output logic [1:0]  m_tuser   // status
);
	import lpht_pkg::*;
`include "linear_probe_hash_table_unit_macros.svh"
	localparam int AW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);
	localparam int KW = 8 * KEY_BYTES;
	localparam int MW = 1 + KW + DATA_BITS + 32;

	logic [MW-1:0] mem [SLOTS];
	logic [MW-1:0] rd_s1;
	logic [AW-1:0] waddr;
	logic [MW-1:0] wdata;
	logic          we;
	logic [AW-1:0] raddr;

	state_t st_q, st_d;
	logic [CW-1:0] cap_q;
	logic [AW-1:0] idx_q;
	logic [CW-1:0] cnt_q;
	logic          kind_q;
	logic [KW-1:0] key_q;
	logic [DATA_BITS-1:0] data_q;
	logic [31:0]   h_q;
	logic [1:0]    pstat_q;
	logic [AW-1:0] pidx_q;
	logic [31:0]   pdat_q;
	logic [1:0]    stat_q;
	logic [AW-1:0] oidx_q;
	logic [31:0]   odat_q;
	logic          ovalid_q;

	logic [63:0] nkey;
	logic [10:0] capc;
	logic        hdone, mdone;
	logic [31:0] hash;
	logic [CW-1:0] rem;
	logic        used_r, hit;
	logic [KW-1:0] key_r;
	logic [DATA_BITS-1:0] dat_r;
	logic [31:0] h_r;
	logic        last_probe;

	always_comb begin
		logic stop;
		stop = 1'b0;
		nkey = '0;
		for (int b = 0; b < KEY_BYTES; b++) begin
			if (s_tdata[8*b +: 8] == 8'd0) stop = 1'b1;
			if (!stop) nkey[8*b +: 8] = s_tdata[8*b +: 8];
		end
	end
	assign capc = 11'(cfg_wdata) + 11'(cfg_wdata[9:1]) + 11'(CAP_PAD);

	lpht_hash #(.KEY_BYTES(KEY_BYTES)) u_hash (
		.clk(clk), .arst_n(arst_n), .start(st_q == S_IDLE && s_tvalid && s_tready),
		.key(nkey), .done(hdone), .hash(hash)
	);
	lpht_mod #(.CW(CW)) u_mod (
		.clk(clk), .arst_n(arst_n), .start(st_q == S_HASH && hdone),
		.dividend(hash), .divisor(cap_q), .done(mdone), .rem(rem)
	);

	assign {used_r, key_r, dat_r, h_r} = rd_s1;
	assign hit = used_r && h_r == h_q && key_r == key_q;
	assign last_probe = (cnt_q + 1'b1) == cap_q;
	assign raddr = idx_q;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_s1 <= mem[raddr];
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			S_CLEAR: if (cnt_q == CW'(SLOTS - 1)) st_d = S_IDLE;
			S_IDLE: if (cfg_we) st_d = S_CLEAR;
				else if (s_tvalid) st_d = S_HASH;
			S_HASH: if (hdone) st_d = S_MOD;
			S_MOD: if (mdone) st_d = S_READ;
			S_READ: st_d = S_CHECK;
			S_CHECK: if (!used_r || hit || last_probe) st_d = S_OUT;
				else st_d = S_READ;
			S_OUT: if (!ovalid_q || m_tready) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = idx_q;
		wdata = {1'b1, key_q, data_q, h_q};
		unique case (st_q)
			S_CLEAR: begin
				we = 1'b1;
				waddr = cnt_q[AW-1:0];
				wdata = '0;
			end
			S_CHECK: we = !used_r && kind_q;
			default: we = 1'b0;
		endcase
	end

	assign s_tready = st_q == S_IDLE && !cfg_we;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
			cap_q <= CW'(CAP_PAD);
			cnt_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == S_OUT && st_d == S_IDLE) ovalid_q <= 1'b1;
			else if (m_tvalid && m_tready) ovalid_q <= 1'b0;
			if (st_q == S_CLEAR) cnt_q <= cnt_q + 1'b1;
			if (st_q == S_IDLE && cfg_we) begin
				cnt_q <= '0;
				cap_q <= (capc > 11'(SLOTS) || SLOTS > 1023) &&
					(32'(capc) > 32'(SLOTS)) ? CW'(SLOTS) : CW'(capc);
			end
			if (st_q == S_MOD) cnt_q <= '0;
			if (st_q == S_CHECK && st_d == S_READ) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			key_q <= nkey[KW-1:0];
			data_q <= s_tdata[64 +: DATA_BITS];
		end
		if (st_q == S_MOD && mdone) begin
			idx_q <= rem[AW-1:0];
			h_q <= hash;
		end
		if (st_q == S_CHECK) begin
			if (hit) begin
				pstat_q <= ST_FOUND;
				pidx_q <= idx_q;
				pdat_q <= 32'(dat_r);
			end else if (!used_r && kind_q) begin
				pstat_q <= ST_INSERTED;
				pidx_q <= idx_q;
				pdat_q <= 32'(data_q);
			end else begin
				pstat_q <= kind_q ? ST_FULL : ST_NOT_FOUND;
				pidx_q <= '0;
				pdat_q <= '0;
			end
			if (st_d == S_READ)
				idx_q <= ((CW'(idx_q) + 1'b1) == cap_q) ? '0 : idx_q + 1'b1;
		end
		if (st_q == S_OUT && st_d == S_IDLE) begin
			stat_q <= pstat_q;
			oidx_q <= pidx_q;
			odat_q <= pdat_q;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tuser = stat_q;
	assign m_tdata = {6'd0, odat_q, 10'(oidx_q)};

	`LPH_ASSERT_IMP(a_rdy_idle, clk, arst_n, s_tready, st_q == S_IDLE)
	`LPH_ASSERT_IMP(a_idx_cap, clk, arst_n, st_q == S_CHECK, CW'(idx_q) < cap_q)
	`LPH_ASSERT_NXT(a_clr_hold, clk, arst_n, st_q == S_CLEAR, !m_tvalid || $past(m_tvalid))
	`LPH_ASSERT_IMP(a_cap_range, clk, arst_n, 1'b1, cap_q >= CW'(CAP_PAD))
endmodule

// ===== tb/linear_probe_hash_table_unit_tb.sv =====
// Testbench for the hash table unit: a scoreboard that predicts each lookup and insert.
`timescale 1ns / 1ps

module linear_probe_hash_table_unit_tb;
	import lpht_pkg::*;

	localparam int NSLOTS = 1024;
	localparam int IDLE_PCT = 36;
	localparam int WATCHDOG_LIMIT = 40000;
	localparam int DRAIN_CYCLES = 60;
	localparam int HOLD_CYCLES = 2000;
	localparam bit KIND_FIND = 1'b0;
	localparam bit KIND_ENTER = 1'b1;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  slot;
		logic [31:0] data;
	} lookup_result_t;

	class hash_table_scoreboard;
		bit              used [NSLOTS];
		logic [63:0]     keys [NSLOTS];
		logic [31:0]     datas [NSLOTS];
		logic [31:0]     hashes [NSLOTS];
		int unsigned     capacity;
		lookup_result_t  expected_results [$];
		int              errors;

		function new();
			set_capacity(10'd0);
			errors = 0;
		endfunction

		function void set_capacity(logic [9:0] req);
			int unsigned c;
			c = req + req / 2 + CAP_PAD;
			capacity = (c > NSLOTS) ? NSLOTS : c;
			foreach (used[i])
				used[i] = 1'b0;
		endfunction

		function void note_request(bit kind, logic [63:0] raw, logic [31:0] din);
			logic [63:0] key;
			logic [31:0] h;
			lookup_result_t r;
			int unsigned i;
			key = '0;
			h = FNV_OFFSET;
			for (int b = 0; b < 8; b++) begin
				if (raw[8*b +: 8] == 8'd0)
					break;
				key[8*b +: 8] = raw[8*b +: 8];
				h = (h ^ {24'd0, raw[8*b +: 8]}) * FNV_PRIME;
			end
			r = '{status: (kind == KIND_ENTER) ? ST_FULL : ST_NOT_FOUND, slot: '0, data: '0};
			i = h % capacity;
			for (int n = 0; n < capacity; n++) begin
				if (!used[i]) begin
					if (kind == KIND_ENTER) begin
						used[i] = 1'b1;
						keys[i] = key;
						datas[i] = din;
						hashes[i] = h;
						r = '{status: ST_INSERTED, slot: i[9:0], data: din};
					end else begin
						r.status = ST_NOT_FOUND;
					end
					break;
				end
				if (hashes[i] == h && keys[i] == key) begin
					r = '{status: ST_FOUND, slot: i[9:0], data: datas[i]};
					break;
				end
				i = (i + 1 >= capacity) ? 0 : i + 1;
			end
			expected_results.push_back(r);
		endfunction

		function void check_result(lookup_result_t got);
			lookup_result_t exp;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result status=%0d slot=%0d data=%h", $time,
					got.status, got.slot, got.data);
				errors++;
				return;
			end
			exp = expected_results.pop_front();
			if (got.status !== exp.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
				errors++;
			end
			if (got.slot !== exp.slot) begin
				$display("%0t: slot_index expected %0d actual %0d", $time, exp.slot, got.slot);
				errors++;
			end
			if (got.data !== exp.data) begin
				$display("%0t: data_out expected %h actual %h", $time, exp.data, got.data);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [9:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;
	logic        s_tuser = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;
	logic [1:0]  m_tuser;

	hash_table_scoreboard sb = new();
	bit          steady = 1'b0;
	bit          hold_request = 1'b0;
	int          hold_left = 0;
	int          quiet_cycles = 0;
	logic [63:0] key_pool [$];

	always #5 clk = ~clk;

	linear_probe_hash_table_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result('{status: m_tuser, slot: m_tdata[9:0], data: m_tdata[41:10]});
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("linear_probe_hash_table_unit_tb NOT OK");
			$finish;
		end
	end

	task automatic send_request(bit kind, logic [63:0] key, logic [31:0] din);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {din, key};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(kind, key, din);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [9:0] req);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= req;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_capacity(req);
	endtask

	function automatic logic [63:0] random_key();
		logic [63:0] k;
		k = {$urandom, $urandom};
		case ($urandom_range(3))
			0: k[8*$urandom_range(7) +: 8] = 8'd0;
			1: k = k >> (8 * $urandom_range(7));
			default: ;
		endcase
		return k;
	endfunction

	task automatic run_phase(logic [9:0] req, int count, int pool_size);
		logic [63:0] k;
		write_capacity(req);
		key_pool.delete();
		repeat (pool_size) key_pool.push_back(random_key());
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(9) == 0)
				k = random_key();
			else
				k = key_pool[$urandom_range(pool_size - 1)];
			send_request($urandom_range(99) < 55 ? KIND_ENTER : KIND_FIND, k, $urandom);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part on the reset capacity of eight slots.
		send_request(KIND_FIND, 64'd0, 32'h0);
		send_request(KIND_ENTER, 64'd0, 32'hFFFF_FFFF);
		send_request(KIND_FIND, 64'd0, 32'h0);
		send_request(KIND_ENTER, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678);
		send_request(KIND_FIND, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
		send_request(KIND_ENTER, 64'h1122_0000_0000_00AB, 32'hA5A5_A5A5);
		send_request(KIND_FIND, 64'h0000_0000_0000_00AB, 32'h0);
		send_request(KIND_ENTER, 64'h0000_0000_0000_00AB, 32'h5A5A_5A5A);
		for (int n = 1; n <= 7; n++)
			send_request(KIND_ENTER, 64'h100 + n, $urandom);
		send_request(KIND_FIND, 64'h77, 32'h0);
		send_request(KIND_ENTER, 64'h77, 32'h0);
		send_request(KIND_FIND, 64'h105, 32'h0);
		send_request(KIND_FIND, 64'h8000_0000_0000_0001, 32'hFFFF_FFFF);

		run_phase(10'd0, 230, 12);
		run_phase(10'd1, 200, 14);
		hold_request = 1'b1;
		run_phase(10'd5, 250, 20);
		steady = 1'b1;
		run_phase(10'd40, 250, 60);
		steady = 1'b0;
		run_phase(10'd677, 400, 200);
		run_phase(10'd1023, 200, 120);
		run_phase(10'd300, 200, 80);

		wait_idle();
		if (sb.errors == 0)
			$display("linear_probe_hash_table_unit_tb OK");
		else
			$display("linear_probe_hash_table_unit_tb NOT OK");
		$finish;
	end
endmodule
